### src/jcgm_pkg.sv
// Shared types and constants for the joystick cursor and gesture matcher.
// Used by jcgm_datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package jcgm_pkg;

  // Field widths
  localparam int SampleW   = 10;
  localparam int OffsetW   = 10;
  localparam int ThreshW   = 9;
  localparam int PatternW  = 16;
  localparam int ProgressW = 3;
  localparam int DirW      = 2;
  localparam int ImageW    = 64;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // Register reset values
  localparam logic [ThreshW-1:0]  DeadZoneReset  = 9'd32;
  localparam logic [ThreshW-1:0]  ThresholdReset = 9'd500;
  localparam logic [PatternW-1:0] PatternReset   = 16'd61008;

  // Axis centre reading
  localparam logic [SampleW-1:0] CentreReading = 10'd512;

  // Last pattern position
  localparam logic [ProgressW-1:0] LastSymbol = 3'd7;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEAD_ZONE = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_PATTERN   = 2'd2
  } cfg_idx_t;

  // Direction codes
  typedef enum logic [DirW-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // Gesture tracking state carried between items
  typedef struct packed {
    logic [ProgressW-1:0] progress;
    dir_t                 dir;
    logic                 pending;
  } gest_state_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [ThreshW-1:0]  dead_zone;
    logic [ThreshW-1:0]  threshold;
    logic [PatternW-1:0] pattern;
  } gest_cfg_t;

endpackage

### src/jcgm_datapath.sv
// Combinational datapath: dead zone, cursor image and gesture step for one beat.
// Depends on jcgm_pkg for widths, codes and the state and config structs.
`timescale 1ns / 1ps

module jcgm_datapath (
  input  logic [jcgm_pkg::SampleW-1:0]   x_sample,
  input  logic [jcgm_pkg::SampleW-1:0]   y_sample,
  input  jcgm_pkg::gest_cfg_t            cfg,
  input  jcgm_pkg::gest_state_t          state_cur,
  output jcgm_pkg::gest_state_t          state_nxt,
  output logic [jcgm_pkg::ImageW-1:0]    cursor_image,
  output logic signed [jcgm_pkg::OffsetW-1:0] x_offset,
  output logic signed [jcgm_pkg::OffsetW-1:0] y_offset,
  output logic [jcgm_pkg::ProgressW-1:0] match_progress,
  output logic                           pattern_matched
);

  logic [jcgm_pkg::OffsetW-1:0] x_raw, y_raw, x_mag, y_mag;
  logic                         x_centred, y_centred;
  logic [jcgm_pkg::SampleW-1:0] x_read, y_read;
  logic [3:0]                   x_q, y_q;
  logic [2:0]                   x_col, y_row, col_shift;
  logic [8:0]                   pair_mask;
  logic [7:0]                   col_mask;
  logic [jcgm_pkg::DirW-1:0]    want;
  logic signed [jcgm_pkg::OffsetW:0] x_ext, y_ext, thr_pos, thr_neg;
  jcgm_pkg::gest_state_t        after_check;

  // Centre each axis: flipping the top bit subtracts 512
  assign x_raw = {~x_sample[jcgm_pkg::SampleW-1], x_sample[jcgm_pkg::SampleW-2:0]};
  assign y_raw = {~y_sample[jcgm_pkg::SampleW-1], y_sample[jcgm_pkg::SampleW-2:0]};
  assign x_mag = x_raw[jcgm_pkg::OffsetW-1] ? (10'd0 - x_raw) : x_raw;
  assign y_mag = y_raw[jcgm_pkg::OffsetW-1] ? (10'd0 - y_raw) : y_raw;

  // Apply the dead zone
  assign x_centred = x_mag < {1'b0, cfg.dead_zone};
  assign y_centred = y_mag < {1'b0, cfg.dead_zone};
  assign x_offset  = x_centred ? '0 : $signed(x_raw);
  assign y_offset  = y_centred ? '0 : $signed(y_raw);
  assign x_read    = x_centred ? jcgm_pkg::CentreReading : x_sample;
  assign y_read    = y_centred ? jcgm_pkg::CentreReading : y_sample;

  // Column mask from the x reading
  assign x_q       = x_read[jcgm_pkg::SampleW-1:6];
  assign x_col     = x_q[3:1];
  assign col_shift = 3'd7 - x_col;
  assign pair_mask = 9'd3 << col_shift;
  assign col_mask  = x_q[0] ? (8'd1 << col_shift) : pair_mask[7:0];

  // Place the mask in one or two rows from the y reading
  assign y_q   = y_read[jcgm_pkg::SampleW-1:6];
  assign y_row = y_q[3:1];

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      if ((y_row == r[2:0]) ||
          (!y_q[0] && (y_q != 4'd0) && ((y_row - 3'd1) == r[2:0]))) begin
        cursor_image[8*r +: 8] = col_mask;
      end else begin
        cursor_image[8*r +: 8] = 8'd0;
      end
    end
  end

  // Threshold bounds, sign-extended to compare with the offsets
  assign x_ext   = {x_offset[jcgm_pkg::OffsetW-1], x_offset};
  assign y_ext   = {y_offset[jcgm_pkg::OffsetW-1], y_offset};
  assign thr_pos = $signed({2'b00, cfg.threshold});
  assign thr_neg = $signed(11'd0 - {2'b00, cfg.threshold});
  assign want    = cfg.pattern[{state_cur.progress, 1'b0} +: jcgm_pkg::DirW];

  // Check the latched direction on return to centre
  always_comb begin
    after_check     = state_cur;
    pattern_matched = 1'b0;
    if ((x_offset == '0) && (y_offset == '0) && state_cur.pending) begin
      if (want == state_cur.dir) begin
        if (state_cur.progress == jcgm_pkg::LastSymbol) begin
          after_check.progress = '0;
          pattern_matched      = 1'b1;
        end else begin
          after_check.progress = state_cur.progress + 3'd1;
        end
      end else begin
        after_check.progress = '0;
      end
      after_check.dir     = jcgm_pkg::DIR_UP;
      after_check.pending = 1'b0;
    end
  end

  // Latch a new direction, right first, then left, down, up
  always_comb begin
    state_nxt = after_check;
    if (!after_check.pending) begin
      if (x_ext > thr_pos) begin
        state_nxt.dir     = jcgm_pkg::DIR_RIGHT;
        state_nxt.pending = 1'b1;
      end else if (x_ext < thr_neg) begin
        state_nxt.dir     = jcgm_pkg::DIR_LEFT;
        state_nxt.pending = 1'b1;
      end else if (y_ext > thr_pos) begin
        state_nxt.dir     = jcgm_pkg::DIR_DOWN;
        state_nxt.pending = 1'b1;
      end else if (y_ext < thr_neg) begin
        state_nxt.dir     = jcgm_pkg::DIR_UP;
        state_nxt.pending = 1'b1;
      end
    end
  end

  assign match_progress = after_check.progress;

endmodule

### src/joystick_cursor_gesture_matcher.sv
// Top level of the joystick cursor and gesture matcher: registers and handshakes.
// Depends on jcgm_pkg and jcgm_datapath.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid/in_stall with in_x_sample and in_y_sample; a beat is
//   taken at a rising edge with in_valid high and in_stall low.
//   Result channel: out_valid/out_stall with the cursor image, both offsets,
//   match progress and the matched pulse; one result beat per input beat.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 dead zone, 1 threshold, 2 pattern word; other
//   indexes are ignored. Write only while the block is idle.
//   A beat passes the input register, then the result register. Throughput:
//   one beat per cycle while out_stall is low, set by the single pass
//   of the datapath between the two registers, which also updates the
//   gesture state once per beat.
//   Reset (rst_n low, synchronous): both registers empty, gesture state
//   cleared, configuration back to dead zone 32, threshold 500, pattern 61008.
//   Stall: a stalled result holds; the input register still takes one more
//   beat, then in_stall rises until the result is taken.
module joystick_cursor_gesture_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [jcgm_pkg::SampleW-1:0]        in_x_sample,
  input  logic [jcgm_pkg::SampleW-1:0]        in_y_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [jcgm_pkg::ImageW-1:0]         out_cursor_image,
  output logic signed [jcgm_pkg::OffsetW-1:0] out_x_offset,
  output logic signed [jcgm_pkg::OffsetW-1:0] out_y_offset,
  output logic [jcgm_pkg::ProgressW-1:0]      out_match_progress,
  output logic                                out_pattern_matched,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jcgm_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [jcgm_pkg::CfgDataW-1:0]       cfg_data
);

  jcgm_pkg::gest_cfg_t          cfg_r;
  jcgm_pkg::gest_state_t        state_r, state_nxt;
  logic                         s1_valid_r;
  logic [jcgm_pkg::SampleW-1:0] s1_x_r, s1_y_r;
  logic                         s1_adv, in_take;
  logic [jcgm_pkg::ImageW-1:0]  image_nxt;
  logic signed [jcgm_pkg::OffsetW-1:0] x_off_nxt, y_off_nxt;
  logic [jcgm_pkg::ProgressW-1:0] prog_nxt;
  logic                         matched_nxt;

  // Handshake control
  assign s1_adv    = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone <= jcgm_pkg::DeadZoneReset;
      cfg_r.threshold <= jcgm_pkg::ThresholdReset;
      cfg_r.pattern   <= jcgm_pkg::PatternReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jcgm_pkg::CFG_DEAD_ZONE: cfg_r.dead_zone <= cfg_data[jcgm_pkg::ThreshW-1:0];
        jcgm_pkg::CFG_THRESHOLD: cfg_r.threshold <= cfg_data[jcgm_pkg::ThreshW-1:0];
        jcgm_pkg::CFG_PATTERN:   cfg_r.pattern   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register: samples
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r <= in_x_sample;
      s1_y_r <= in_y_sample;
    end
  end

  jcgm_datapath u_datapath (
    .x_sample        (s1_x_r),
    .y_sample        (s1_y_r),
    .cfg             (cfg_r),
    .state_cur       (state_r),
    .state_nxt       (state_nxt),
    .cursor_image    (image_nxt),
    .x_offset        (x_off_nxt),
    .y_offset        (y_off_nxt),
    .match_progress  (prog_nxt),
    .pattern_matched (matched_nxt)
  );

  // Advance the gesture state once per beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.progress <= '0;
      state_r.dir      <= jcgm_pkg::DIR_UP;
      state_r.pending  <= 1'b0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cursor_image    <= image_nxt;
      out_x_offset        <= x_off_nxt;
      out_y_offset        <= y_off_nxt;
      out_match_progress  <= prog_nxt;
      out_pattern_matched <= matched_nxt;
    end
  end

endmodule

### src/jcgm_checker.sv
// Port-level assertions for the joystick cursor and gesture matcher.
// Depends on jcgm_pkg; bound to joystick_cursor_gesture_matcher below.
`timescale 1ns / 1ps

module jcgm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [jcgm_pkg::ImageW-1:0]         out_cursor_image,
  input logic signed [jcgm_pkg::OffsetW-1:0] out_x_offset,
  input logic [jcgm_pkg::ProgressW-1:0]      out_match_progress,
  input logic                                out_pattern_matched
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_image) &&
      $stable(out_x_offset) && $stable(out_match_progress))
    else $error("stalled result changed");

  // A completed pattern leaves progress cleared
  a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_matched |-> out_match_progress == '0)
    else $error("pattern matched with progress not cleared");

  // The cursor lights one to four pixels
  a_cursor_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_cursor_image) >= 1) &&
      ($countones(out_cursor_image) <= 4))
    else $error("cursor image pixel count out of range");

endmodule

bind joystick_cursor_gesture_matcher jcgm_checker u_jcgm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_cursor_image    (out_cursor_image),
  .out_x_offset        (out_x_offset),
  .out_match_progress  (out_match_progress),
  .out_pattern_matched (out_pattern_matched)
);

### tb/sv/tb_joystick_cursor_gesture_matcher.sv
// Self-checking testbench for joystick_cursor_gesture_matcher: random sample pairs and
// gesture runs against an in-bench cursor and gesture predictor, over several register settings.
// Depends on jcgm_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_joystick_cursor_gesture_matcher;

  localparam int CycleLimit = 500000;
  localparam logic [jcgm_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;

  typedef struct {
    logic [jcgm_pkg::SampleW-1:0] x;
    logic [jcgm_pkg::SampleW-1:0] y;
  } stick_sample_t;

  typedef struct {
    logic [jcgm_pkg::ImageW-1:0]         image;
    logic signed [jcgm_pkg::OffsetW-1:0] x_off;
    logic signed [jcgm_pkg::OffsetW-1:0] y_off;
    logic [jcgm_pkg::ProgressW-1:0]      progress;
    logic                                matched;
  } cursor_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [jcgm_pkg::SampleW-1:0] in_x_sample = '0;
  logic [jcgm_pkg::SampleW-1:0] in_y_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [jcgm_pkg::ImageW-1:0] out_cursor_image;
  logic signed [jcgm_pkg::OffsetW-1:0] out_x_offset;
  logic signed [jcgm_pkg::OffsetW-1:0] out_y_offset;
  logic [jcgm_pkg::ProgressW-1:0] out_match_progress;
  logic out_pattern_matched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jcgm_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [jcgm_pkg::CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the registers and gesture state
  logic [jcgm_pkg::ThreshW-1:0]   zone_width   = jcgm_pkg::DeadZoneReset;
  logic [jcgm_pkg::ThreshW-1:0]   latch_level  = jcgm_pkg::ThresholdReset;
  logic [jcgm_pkg::PatternW-1:0]  symbol_word  = jcgm_pkg::PatternReset;
  logic [jcgm_pkg::ProgressW-1:0] symbols_done = '0;
  jcgm_pkg::dir_t                 held_dir     = jcgm_pkg::DIR_UP;
  logic                           dir_held     = 1'b0;

  stick_sample_t  pending_samples[$];
  cursor_result_t awaited_cursors[$];
  int samples_sent = 0;
  int samples_taken = 0;
  int queued = 0;
  int mismatch_count = 0;
  int cycles = 0;

  joystick_cursor_gesture_matcher u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_x_sample         (in_x_sample),
    .in_y_sample         (in_y_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_image    (out_cursor_image),
    .out_x_offset        (out_x_offset),
    .out_y_offset        (out_y_offset),
    .out_match_progress  (out_match_progress),
    .out_pattern_matched (out_pattern_matched),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #6 clk = ~clk;

  // Work out the result of one sample pair and advance the gesture state
  function automatic cursor_result_t predict_cursor(input logic [jcgm_pkg::SampleW-1:0] xs,
                                                    input logic [jcgm_pkg::SampleW-1:0] ys);
    cursor_result_t r;
    int xo, yo, thr, xq, yq;
    logic [7:0] mask;
    logic [jcgm_pkg::DirW-1:0] want;
    xo = int'(xs) - 512;
    yo = int'(ys) - 512;
    if ((xo < 0 ? -xo : xo) < int'(zone_width)) xo = 0;
    if ((yo < 0 ? -yo : yo) < int'(zone_width)) yo = 0;
    // a centred axis reads as the centre value
    xq = (xo + 512) / 64;
    yq = (yo + 512) / 64;
    r.matched = 1'b0;

    // both axes back at centre: check the held direction against the pattern
    if (xo == 0 && yo == 0 && dir_held) begin
      want = symbol_word[2*symbols_done +: 2];
      if (want == held_dir) begin
        if (symbols_done == jcgm_pkg::LastSymbol) begin
          symbols_done = '0;
          r.matched = 1'b1;
        end else begin
          symbols_done = symbols_done + 1'b1;
        end
      end else begin
        symbols_done = '0;
      end
      held_dir = jcgm_pkg::DIR_UP;
      dir_held = 1'b0;
    end

    // cursor: two pixels on even steps, one on odd, truncated at the left edge
    mask = (xq % 2 == 0) ? 8'(3 << (7 - xq / 2)) : 8'(1 << (7 - xq / 2));
    r.image = '0;
    r.image[8*(yq/2) +: 8] = mask;
    if (yq % 2 == 0 && yq >= 1) r.image[8*(yq/2-1) +: 8] = mask;

    // latch a direction, right first, then left, down, up
    thr = int'(latch_level);
    if (!dir_held) begin
      if (xo > thr) begin
        held_dir = jcgm_pkg::DIR_RIGHT;
        dir_held = 1'b1;
      end else if (xo < -thr) begin
        held_dir = jcgm_pkg::DIR_LEFT;
        dir_held = 1'b1;
      end else if (yo > thr) begin
        held_dir = jcgm_pkg::DIR_DOWN;
        dir_held = 1'b1;
      end else if (yo < -thr) begin
        held_dir = jcgm_pkg::DIR_UP;
        dir_held = 1'b1;
      end
    end

    r.x_off = xo[jcgm_pkg::OffsetW-1:0];
    r.y_off = yo[jcgm_pkg::OffsetW-1:0];
    r.progress = symbols_done;
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [jcgm_pkg::SampleW-1:0] any_reading();
    int v;
    v = $urandom_range(0, 1023);
    return v[jcgm_pkg::SampleW-1:0];
  endfunction

  // Reading that lands inside the dead zone
  function automatic logic [jcgm_pkg::SampleW-1:0] near_centre();
    int span, v;
    span = (zone_width == 0) ? 0 : int'(zone_width) - 1;
    v = 512 + int'($urandom_range(0, 2 * span)) - span;
    return v[jcgm_pkg::SampleW-1:0];
  endfunction

  // Sample pair deflected past the threshold in one direction
  function automatic stick_sample_t deflected(input jcgm_pkg::dir_t d);
    stick_sample_t s;
    int lo, mag, t, v, w;
    lo = int'(latch_level) + 1;
    if (lo < int'(zone_width)) lo = int'(zone_width);
    t = int'(latch_level);
    mag = int'($urandom_range(512, lo));
    // for down and up, keep the x axis within the threshold
    w = 512 + int'($urandom_range(0, 2 * t)) - t;
    case (d)
      jcgm_pkg::DIR_RIGHT: begin
        v = 512 + (mag > 511 ? 511 : mag);
        s.x = v[jcgm_pkg::SampleW-1:0];
        s.y = any_reading();
      end
      jcgm_pkg::DIR_LEFT: begin
        v = 512 - mag;
        s.x = v[jcgm_pkg::SampleW-1:0];
        s.y = any_reading();
      end
      jcgm_pkg::DIR_DOWN: begin
        v = 512 + (mag > 511 ? 511 : mag);
        s.y = v[jcgm_pkg::SampleW-1:0];
        s.x = w[jcgm_pkg::SampleW-1:0];
      end
      default: begin
        v = 512 - mag;
        s.y = v[jcgm_pkg::SampleW-1:0];
        s.x = w[jcgm_pkg::SampleW-1:0];
      end
    endcase
    return s;
  endfunction

  task automatic queue_sample(input logic [jcgm_pkg::SampleW-1:0] xs,
                              input logic [jcgm_pkg::SampleW-1:0] ys);
    stick_sample_t s;
    s.x = xs;
    s.y = ys;
    pending_samples.push_back(s);
    queued++;
  endtask

  // One gesture: deflect, perhaps some noise, then return to centre
  task automatic push_gesture(input jcgm_pkg::dir_t d);
    stick_sample_t s;
    repeat ($urandom_range(1, 3)) begin
      s = deflected(d);
      queue_sample(s.x, s.y);
    end
    if ($urandom_range(0, 7) == 0) queue_sample(any_reading(), any_reading());
    repeat ($urandom_range(1, 3)) queue_sample(near_centre(), near_centre());
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Register write; valid stays high so back-to-back writes need no re-raise
  task automatic cfg_write(input logic [jcgm_pkg::CfgIdxW-1:0] idx,
                           input logic [jcgm_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      jcgm_pkg::CFG_DEAD_ZONE: zone_width  = data[jcgm_pkg::ThreshW-1:0];
      jcgm_pkg::CFG_THRESHOLD: latch_level = data[jcgm_pkg::ThreshW-1:0];
      jcgm_pkg::CFG_PATTERN:   symbol_word = data[jcgm_pkg::PatternW-1:0];
      default: ;
    endcase
  endtask

  // Wait for the sender to drain and every result to arrive
  task automatic settle();
    int waited;
    waited = 0;
    while (pending_samples.size() != 0 || in_valid) @(posedge clk);
    while (awaited_cursors.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Sender: present queued pairs, hold a stalled beat, insert gaps
  int gap_left = 0;
  int in_calm = 0;
  always @(negedge clk) begin : feed_samples
    stick_sample_t s;
    if (in_calm > 0) in_calm--;
    else if ($urandom_range(0, 99) == 0) in_calm = $urandom_range(40, 150);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && samples_taken != samples_sent)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_x_sample <= s.x;
        in_y_sample <= s.y;
        in_valid <= 1'b1;
        samples_sent++;
        gap_left = (in_calm > 0 || out_stall) ? 0 : idle_span();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs to back the block up
  int stall_left = 0;
  int out_calm = 0;
  int holdoff_left = 0;
  int next_holdoff = 300;
  always @(negedge clk) begin : pace_results
    if (out_calm > 0) out_calm--;
    else if ($urandom_range(0, 99) == 0) out_calm = $urandom_range(40, 150);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (samples_taken >= next_holdoff) begin
      holdoff_left = 80;
      next_holdoff += 600;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = (out_calm > 0) ? 0 : idle_span();
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : watch_results
    cursor_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      awaited_cursors.push_back(predict_cursor(in_x_sample, in_y_sample));
      samples_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_cursors.size() == 0) begin
        flag_mismatch("result beat with nothing awaited");
      end else begin
        want = awaited_cursors.pop_front();
        if (out_cursor_image !== want.image)
          flag_mismatch($sformatf("cursor_image got %h want %h", out_cursor_image, want.image));
        if (out_x_offset !== want.x_off)
          flag_mismatch($sformatf("x_offset got %0d want %0d", out_x_offset, want.x_off));
        if (out_y_offset !== want.y_off)
          flag_mismatch($sformatf("y_offset got %0d want %0d", out_y_offset, want.y_off));
        if (out_match_progress !== want.progress)
          flag_mismatch($sformatf("match_progress got %0d want %0d",
                                  out_match_progress, want.progress));
        if (out_pattern_matched !== want.matched)
          flag_mismatch($sformatf("pattern_matched got %b want %b",
                                  out_pattern_matched, want.matched));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("joystick_cursor_gesture_matcher regression: fail");
      $finish;
    end
  end

  // Stimulus: directed opening, then phases of random gestures under new settings
  initial begin : run_phases
    logic [31:0] rnd;
    logic [31:0] rnd_b;
    jcgm_pkg::dir_t d;
    int quota;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      queued = 0;
      quota = (phase == 0) ? 300 : 220;
      if (phase == 0) begin
        // centre, corners and dead-zone edges
        queue_sample(10'd512, 10'd512);
        queue_sample(10'd0, 10'd0);
        queue_sample(10'd543, 10'd481);
        queue_sample(10'd1023, 10'd1023);
        queue_sample(10'd544, 10'd480);
        queue_sample(10'd1012, 10'd512);
        queue_sample(10'd512, 10'd512);
        // full pattern at full deflection, completing it once
        for (int k = 0; k < 8; k++) begin
          d = jcgm_pkg::dir_t'(symbol_word[2*k +: 2]);
          case (d)
            jcgm_pkg::DIR_RIGHT: queue_sample(10'd1023, 10'd512);
            jcgm_pkg::DIR_LEFT:  queue_sample(10'd0, 10'd512);
            jcgm_pkg::DIR_DOWN:  queue_sample(10'd512, 10'd1023);
            default:             queue_sample(10'd512, 10'd0);
          endcase
          queue_sample(jcgm_pkg::CentreReading, jcgm_pkg::CentreReading);
        end
        // threshold edge, then a wrong symbol clears progress
        queue_sample(10'd1013, 10'd0);
        queue_sample(jcgm_pkg::CentreReading, jcgm_pkg::CentreReading);
      end else begin
        settle();
        rnd = $urandom();
        rnd_b = $urandom();
        case (phase)
          1: begin
            // zero dead zone and threshold, stray high bits set
            cfg_write(jcgm_pkg::CFG_DEAD_ZONE, 16'hFE00);
            cfg_write(jcgm_pkg::CFG_THRESHOLD, 16'h7E00);
            cfg_write(jcgm_pkg::CFG_PATTERN, rnd[15:0]);
            cfg_write(CfgUnmapped, rnd[31:16]);
          end
          2: begin
            cfg_write(jcgm_pkg::CFG_DEAD_ZONE, {rnd[6:0], 9'h1FF});
            cfg_write(jcgm_pkg::CFG_THRESHOLD, 16'hFFFF);
            cfg_write(jcgm_pkg::CFG_PATTERN, 16'hFFFF);
          end
          3: begin
            cfg_write(jcgm_pkg::CFG_DEAD_ZONE, 16'h0001);
            cfg_write(jcgm_pkg::CFG_THRESHOLD, {rnd[22:16], rnd[8:0]});
            cfg_write(jcgm_pkg::CFG_PATTERN, 16'h0000);
          end
          default: begin
            cfg_write(jcgm_pkg::CFG_DEAD_ZONE, {rnd[31:25], 3'b000, rnd[5:0]});
            cfg_write(jcgm_pkg::CFG_THRESHOLD, {rnd[24:18], rnd[17:9]});
            cfg_write(jcgm_pkg::CFG_PATTERN, rnd_b[15:0]);
            cfg_write(CfgUnmapped, rnd_b[31:16]);
          end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
      end

      // mostly pattern runs with the odd wrong symbol, the rest noise
      while (queued < quota) begin
        if ($urandom_range(0, 99) < 80) begin
          for (int k = 0; k < 8; k++) begin
            rnd = $urandom();
            d = jcgm_pkg::dir_t'(symbol_word[2*k +: 2]);
            if (rnd[7:4] == 4'd0) d = jcgm_pkg::dir_t'(rnd[1:0]);
            push_gesture(d);
          end
        end else begin
          repeat ($urandom_range(1, 6)) queue_sample(any_reading(), any_reading());
        end
      end
    end

    settle();
    if (awaited_cursors.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_cursors.size()));
    if (mismatch_count == 0) begin
      $display("joystick_cursor_gesture_matcher regression: pass");
    end else begin
      $display("joystick_cursor_gesture_matcher regression: fail");
    end
    $finish;
  end

endmodule
